### rtl/cfcd_pkg.sv
// ----------------------------------------------------------------------------
// cfcd_pkg: shared types and constants for the COBS frame command detector
// Holds the frame size limit, the reboot command bytes, status codes and the
// structs that pass between the stages.
// ----------------------------------------------------------------------------
package cfcd_pkg;

  localparam int MAX_FRAME = 256;
  localparam int RAW_W     = $clog2(MAX_FRAME + 1);
  localparam int DEC_W     = 9;
  localparam int DEC_SAT   = 511;
  localparam int LEN_W     = 8;
  localparam int LEN_SAT   = 255;
  localparam int CMD_LEN   = 27;
  localparam int IDX_W     = $clog2(CMD_LEN);

  localparam logic [7:0] DELIM_BYTE = 8'h00;
  localparam logic [7:0] FULL_CODE  = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_CORRUPT = 2'd0,
    STATUS_REBOOT  = 2'd1,
    STATUS_OTHER   = 2'd2
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
  } result_t;

  // Expected decoded bytes of the reboot command
  function automatic logic [7:0] cmd_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:    val = 8'hA1;
      5'd1:    val = 8'h64;
      5'd2:    val = 8'h74;
      5'd3:    val = 8'h79;
      5'd4:    val = 8'h70;
      5'd5:    val = 8'h65;
      5'd6:    val = 8'h74;
      5'd7:    val = 8'h72;
      5'd8:    val = 8'h65;
      5'd9:    val = 8'h62;
      5'd10:   val = 8'h6F;
      5'd11:   val = 8'h6F;
      5'd12:   val = 8'h74;
      5'd13:   val = 8'h5F;
      5'd14:   val = 8'h74;
      5'd15:   val = 8'h6F;
      5'd16:   val = 8'h5F;
      5'd17:   val = 8'h62;
      5'd18:   val = 8'h6F;
      5'd19:   val = 8'h6F;
      5'd20:   val = 8'h74;
      5'd21:   val = 8'h6C;
      5'd22:   val = 8'h6F;
      5'd23:   val = 8'h61;
      5'd24:   val = 8'h64;
      5'd25:   val = 8'h65;
      5'd26:   val = 8'h72;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

### rtl/cobs_frame_command_detector_top.sv
// Path: input byte register, then COBS decode, then result register.
// Throughput: 1 byte per cycle; a frame-ending delimiter waits until the
// result register is free or being emptied in the same cycle.
// Reset: synchronous, active high; clears both valid flags and the frame
// state (counts zero, match flag set), so the first byte opens a frame.
// ----------------------------------------------------------------------------
// cobs_frame_command_detector_top: COBS frame command detector
// Decodes a COBS byte stream and reports, per non-empty delimited frame,
// whether it is corrupt, the reboot command or another frame.
// ----------------------------------------------------------------------------
module cobs_frame_command_detector_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] frame_status,
  output logic [7:0] decoded_length
);

  cfcd_pkg::byte_stage_t stage;
  cfcd_pkg::result_t     result;
  logic                  take;
  logic                  load;
  logic                  out_free;

  cfcd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .stage      (stage)
  );

  cfcd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .take     (take),
    .load     (load),
    .result   (result)
  );

  cfcd_out_reg u_out_reg (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .result         (result),
    .out_free       (out_free),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .frame_status   (frame_status),
    .decoded_length (decoded_length)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register overwritten while held");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> stage.valid)
    else $error("input stalled with an empty byte register");

  a_reboot_length: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_status == cfcd_pkg::STATUS_REBOOT) |->
      decoded_length == 8'(cfcd_pkg::CMD_LEN))
    else $error("reboot status with wrong decoded length");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> frame_status <= cfcd_pkg::STATUS_OTHER)
    else $error("undefined frame status");

endmodule

### rtl/cfcd_in_reg.sv
// ----------------------------------------------------------------------------
// cfcd_in_reg: input byte register
// Captures one received byte per request and holds it until the decode
// stage takes it.
// ----------------------------------------------------------------------------
module cfcd_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 take,
  output cfcd_pkg::byte_stage_t stage
);

  logic       valid_q;
  logic [7:0] data_q;

  assign item_stall  = valid_q && !take;
  assign stage.valid = valid_q;
  assign stage.data  = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (item_valid && !item_stall) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      data_q <= rx_byte;
    end
  end

endmodule

### rtl/cfcd_decode.sv
// ----------------------------------------------------------------------------
// cfcd_decode: COBS decode and command compare
// Tracks frame state, decodes one byte per cycle unless a delimiter stalls,
// compares decoded bytes with the reboot command, classifies at a delimiter.
// ----------------------------------------------------------------------------
module cfcd_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  cfcd_pkg::byte_stage_t stage,
  input  logic                  out_free,
  output logic                  take,
  output logic                  load,
  output cfcd_pkg::result_t     result
);

  logic [cfcd_pkg::RAW_W-1:0] raw_count, raw_count_next;
  logic [7:0]                 code_remaining, code_remaining_next;
  logic                       pending_zero, pending_zero_next;
  logic [cfcd_pkg::DEC_W-1:0] decoded_count, decoded_count_next;
  logic                       pattern_match, pattern_match_next;

  logic       is_delim;
  logic       emits;
  logic       dec_en;
  logic [7:0] dec_val;
  logic       in_cmd;
  logic       byte_ok;

  assign is_delim = (stage.data == cfcd_pkg::DELIM_BYTE);
  assign emits    = stage.valid && is_delim && (raw_count != '0);
  assign take     = stage.valid && (!emits || out_free);
  assign load     = take && emits;

  assign in_cmd  = (decoded_count < cfcd_pkg::DEC_W'(cfcd_pkg::CMD_LEN));
  assign byte_ok = in_cmd &&
                   (cfcd_pkg::cmd_byte(decoded_count[cfcd_pkg::IDX_W-1:0]) == dec_val);

  always_comb begin
    if (decoded_count > cfcd_pkg::DEC_W'(cfcd_pkg::LEN_SAT)) begin
      result.length = cfcd_pkg::LEN_W'(cfcd_pkg::LEN_SAT);
    end else begin
      result.length = decoded_count[cfcd_pkg::LEN_W-1:0];
    end
    priority if (code_remaining != '0 || decoded_count == '0) begin
      result.status = cfcd_pkg::STATUS_CORRUPT;
    end else if (pattern_match &&
                 decoded_count == cfcd_pkg::DEC_W'(cfcd_pkg::CMD_LEN)) begin
      result.status = cfcd_pkg::STATUS_REBOOT;
    end else begin
      result.status = cfcd_pkg::STATUS_OTHER;
    end
  end

  always_comb begin
    raw_count_next      = raw_count;
    code_remaining_next = code_remaining;
    pending_zero_next   = pending_zero;
    decoded_count_next  = decoded_count;
    pattern_match_next  = pattern_match;
    dec_en              = 1'b0;
    dec_val             = stage.data;
    if (code_remaining == '0) begin
      dec_en  = pending_zero;
      dec_val = 8'h00;
    end else begin
      dec_en  = 1'b1;
    end
    if (take) begin
      if (is_delim || raw_count >= cfcd_pkg::RAW_W'(cfcd_pkg::MAX_FRAME)) begin
        // end of frame or overflow: drop all frame state
        raw_count_next      = '0;
        code_remaining_next = '0;
        pending_zero_next   = 1'b0;
        decoded_count_next  = '0;
        pattern_match_next  = 1'b1;
      end else begin
        raw_count_next = raw_count + cfcd_pkg::RAW_W'(1);
        if (code_remaining == '0) begin
          code_remaining_next = stage.data - 8'd1;
          pending_zero_next   = (stage.data != cfcd_pkg::FULL_CODE);
        end else begin
          code_remaining_next = code_remaining - 8'd1;
        end
        if (dec_en) begin
          pattern_match_next = pattern_match && byte_ok;
          if (decoded_count < cfcd_pkg::DEC_W'(cfcd_pkg::DEC_SAT)) begin
            decoded_count_next = decoded_count + cfcd_pkg::DEC_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count      <= '0;
      code_remaining <= '0;
      pending_zero   <= 1'b0;
      decoded_count  <= '0;
      pattern_match  <= 1'b1;
    end else begin
      raw_count      <= raw_count_next;
      code_remaining <= code_remaining_next;
      pending_zero   <= pending_zero_next;
      decoded_count  <= decoded_count_next;
      pattern_match  <= pattern_match_next;
    end
  end

endmodule

### rtl/cfcd_out_reg.sv
// ----------------------------------------------------------------------------
// cfcd_out_reg: result register
// Holds one frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cfcd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cfcd_pkg::result_t result,
  output logic              out_free,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        frame_status,
  output logic [7:0]        decoded_length
);

  logic              valid_q;
  cfcd_pkg::result_t data_q;

  assign out_free       = !valid_q || !result_stall;
  assign result_valid   = valid_q;
  assign frame_status   = data_q.status;
  assign decoded_length = data_q.length;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!result_stall) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= result;
    end
  end

endmodule
